// ===== rtl/tcec_pkg.sv =====
// Shared types and constants for the text console escape and cursor engine.
`timescale 1ns / 1ps
`default_nettype none

package tcec_pkg;

	// Largest effective screen dimension and the escape argument ceiling.
	localparam int MAX_DIM   = 4096;
	localparam int ARG_LIMIT = 9999;

	localparam logic [12:0] MAX_DIM_W   = 13'(MAX_DIM);
	localparam logic [13:0] ARG_LIMIT_W = 14'(ARG_LIMIT);

	// Character codes the engine reacts to.
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_J      = 8'h4A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Result queue depth.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Command codes of a result beat.
	typedef enum logic [1:0] {
		CMD_DRAW   = 2'd0,
		CMD_SCROLL = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_GLYPH_WIDTH   = 3'd2,
		REG_GLYPH_HEIGHT  = 3'd3,
		REG_GAP_X         = 3'd4,
		REG_GAP_Y         = 3'd5,
		REG_TAB_CELLS     = 3'd6
	} cfg_idx_t;

	// Configuration register values after reset.
	localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [6:0]  RST_GLYPH_WIDTH   = 7'd8;
	localparam logic [6:0]  RST_GLYPH_HEIGHT  = 7'd8;
	localparam logic [5:0]  RST_GAP_X         = 6'd0;
	localparam logic [5:0]  RST_GAP_Y         = 6'd4;
	localparam logic [7:0]  RST_TAB_CELLS     = 8'd9;

	// Cursor position after reset.
	localparam logic [11:0] RST_CURSOR_Y = 12'd2;

	typedef struct packed {
		logic [12:0] screen_width;
		logic [12:0] screen_height;
		logic [6:0]  glyph_width;
		logic [6:0]  glyph_height;
		logic [5:0]  gap_x;
		logic [5:0]  gap_y;
		logic [7:0]  tab_cells;
	} cfg_t;

	typedef struct packed {
		cmd_t        command;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  glyph;
		logic [6:0]  scroll_pixels;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_escape_cursor_engine.sv =====
// Top level of the text console escape and cursor engine.
//
// Character bytes enter on the in channel (in_valid, in_ready, char_code),
// one beat per byte. Draw, scroll and clear commands leave on the out
// channel (out_valid, out_ready and the result fields), one beat each; a
// byte yields zero, one or two beats, and last marks the final beat of a
// byte. Configuration registers are written through cfg_valid, cfg_ready,
// cfg_index and cfg_data; cfg_ready is always high, and writes must go in
// only while no byte is in flight; the block itself does not enforce it.
// A byte is registered at acceptance and decoded from that register once
// the queue has room, where a single 14x8 multiply by the cell pitch sets
// the path; its beats are written into a four-entry queue, from which the
// first beat of a byte is shown.
// One byte is taken per cycle as long as each yields at most one beat and
// the receiver takes every beat. When the receiver stalls, the queue fills
// and in_ready falls once fewer than two free entries remain while a byte
// waits in the input register; nothing is lost.
// Reset puts the cursor at x 0, y 2, leaves escape mode, empties the queue
// and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module text_console_escape_cursor_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       command,
	output logic [11:0]      pos_x,
	output logic [11:0]      pos_y,
	output logic [7:0]       glyph,
	output logic [6:0]       scroll_pixels,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);
	import tcec_pkg::*;

	cfg_t       cfg_q;
	logic [7:0] char_s1;
	logic       vld_s1;
	logic       room, step;
	res_t       res0, res1, head;
	logic [1:0] res_cnt;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
			cfg_q.glyph_width   <= RST_GLYPH_WIDTH;
			cfg_q.glyph_height  <= RST_GLYPH_HEIGHT;
			cfg_q.gap_x         <= RST_GAP_X;
			cfg_q.gap_y         <= RST_GAP_Y;
			cfg_q.tab_cells     <= RST_TAB_CELLS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= cfg_data[6:0];
				REG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= cfg_data[6:0];
				REG_GAP_X:         cfg_q.gap_x         <= cfg_data[5:0];
				REG_GAP_Y:         cfg_q.gap_y         <= cfg_data[5:0];
				REG_TAB_CELLS:     cfg_q.tab_cells     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register; it drains whenever the queue can take a full item.
	assign step     = vld_s1 && room;
	assign in_ready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
		end
	end

	tcec_cursor u_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_s1 (char_s1),
		.cfg     (cfg_q),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	tcec_res_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (res_cnt),
		.d0         (res0),
		.d1         (res1),
		.pop        (out_valid && out_ready),
		.head_valid (out_valid),
		.head       (head),
		.room       (room)
	);

	// Output beat fields.
	assign command       = head.command;
	assign pos_x         = head.pos_x;
	assign pos_y         = head.pos_y;
	assign glyph         = head.glyph;
	assign scroll_pixels = head.scroll_pixels;
	assign last          = head.last;

endmodule

`default_nettype wire

// ===== rtl/tcec_cursor.sv =====
// Cursor and escape state with the single-pass decode of one character.
`timescale 1ns / 1ps
`default_nettype none

module tcec_cursor (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    char_s1,
	input  wire tcec_pkg::cfg_t cfg,
	output tcec_pkg::res_t     res0,
	output tcec_pkg::res_t     res1,
	output logic [1:0]         res_cnt
);
	import tcec_pkg::*;

	logic [11:0] cursor_x_q, cursor_y_q, cursor_x_d, cursor_y_d;
	logic        in_escape_q, in_escape_d;
	logic [13:0] escape_arg_q, escape_arg_d;

	logic        is_digit;
	logic        do_move, move_left, do_line, x_to_gap, home;
	logic        draw, clear, esc_set, esc_clr, arg_load;
	logic [13:0] mul_n;

	logic [7:0]  pitch;
	logic [21:0] prod, cx_ext, nx;
	logic [12:0] eff_w, eff_h;
	logic        under, wrap_x, line_step, scroll;
	logic [13:0] ny;
	logic [7:0]  sp_sum;
	logic [6:0]  sp;
	logic [16:0] arg10;

	res_t draw_res, scroll_res, clear_res;

	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);

	// Decode the character into cursor actions.
	always_comb begin
		do_move   = 1'b0;
		move_left = 1'b0;
		mul_n     = 14'd1;
		do_line   = 1'b0;
		x_to_gap  = 1'b0;
		home      = 1'b0;
		draw      = 1'b0;
		clear     = 1'b0;
		esc_set   = 1'b0;
		esc_clr   = 1'b0;
		arg_load  = 1'b0;
		if (in_escape_q) begin
			if (is_digit) begin
				arg_load = 1'b1;
			end else if (char_s1 != CH_LBRACK) begin
				esc_clr = 1'b1;
				case (char_s1)
					CH_D: begin
						do_move   = 1'b1;
						move_left = 1'b1;
						mul_n     = escape_arg_q;
					end
					CH_C: begin
						do_move = 1'b1;
						mul_n   = escape_arg_q;
					end
					CH_H: home  = 1'b1;
					CH_J: clear = 1'b1;
					default: ;
				endcase
			end
		end else begin
			case (char_s1)
				CH_LF: begin
					x_to_gap = 1'b1;
					do_line  = 1'b1;
				end
				CH_CR: x_to_gap = 1'b1;
				CH_BS: begin
					do_move   = 1'b1;
					move_left = 1'b1;
				end
				CH_TAB: begin
					do_move = 1'b1;
					mul_n   = {6'd0, cfg.tab_cells};
				end
				CH_ESC: esc_set = 1'b1;
				default: begin
					draw    = 1'b1;
					do_move = 1'b1;
				end
			endcase
		end
	end

	// Horizontal move: one multiply by the cell pitch, then a range check.
	assign pitch  = {1'b0, cfg.glyph_width} + {2'b00, cfg.gap_x};
	assign prod   = mul_n * pitch;
	assign cx_ext = {10'd0, cursor_x_q};
	assign eff_w  = (cfg.screen_width > MAX_DIM_W) ? MAX_DIM_W : cfg.screen_width;
	assign eff_h  = (cfg.screen_height > MAX_DIM_W) ? MAX_DIM_W : cfg.screen_height;
	assign under  = move_left && (prod > cx_ext);
	assign nx     = move_left ? (cx_ext - prod) : (cx_ext + prod);
	assign wrap_x = do_move && (under || (nx >= {9'd0, eff_w}));

	// Vertical step to the next line; past the bottom it becomes a scroll.
	assign line_step = do_line || wrap_x;
	assign ny        = {2'b00, cursor_y_q} + {7'd0, cfg.glyph_height} + {8'd0, cfg.gap_y};
	assign scroll    = line_step && (ny >= {1'b0, eff_h});
	assign sp_sum    = {1'b0, cfg.glyph_height} + {2'b00, cfg.gap_y};
	assign sp        = sp_sum[7] ? 7'h7F : sp_sum[6:0];

	// Decimal argument accumulation with saturation.
	assign arg10 = ({3'd0, escape_arg_q} << 3) + ({3'd0, escape_arg_q} << 1)
		+ {13'd0, char_s1[3:0]};

	// Next state.
	always_comb begin
		cursor_x_d = cursor_x_q;
		if (x_to_gap || home || wrap_x) begin
			cursor_x_d = {6'd0, cfg.gap_x};
		end else if (do_move) begin
			cursor_x_d = nx[11:0];
		end

		cursor_y_d = cursor_y_q;
		if (home) begin
			cursor_y_d = {6'd0, cfg.gap_y};
		end else if (line_step && !scroll) begin
			cursor_y_d = ny[11:0];
		end

		in_escape_d = in_escape_q;
		if (esc_set) begin
			in_escape_d = 1'b1;
		end else if (esc_clr) begin
			in_escape_d = 1'b0;
		end

		escape_arg_d = escape_arg_q;
		if (arg_load) begin
			escape_arg_d = (arg10 > {3'd0, ARG_LIMIT_W}) ? ARG_LIMIT_W : arg10[13:0];
		end else if (esc_clr) begin
			escape_arg_d = 14'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= 12'd0;
			cursor_y_q   <= RST_CURSOR_Y;
			in_escape_q  <= 1'b0;
			escape_arg_q <= 14'd0;
		end else if (step) begin
			cursor_x_q   <= cursor_x_d;
			cursor_y_q   <= cursor_y_d;
			in_escape_q  <= in_escape_d;
			escape_arg_q <= escape_arg_d;
		end
	end

	// Result beats: a draw may be followed by a scroll when the advance wraps past the bottom.
	always_comb begin
		draw_res               = '0;
		draw_res.command       = CMD_DRAW;
		draw_res.pos_x         = cursor_x_q;
		draw_res.pos_y         = cursor_y_q;
		draw_res.glyph         = char_s1;
		draw_res.last          = !scroll;

		scroll_res               = '0;
		scroll_res.command       = CMD_SCROLL;
		scroll_res.scroll_pixels = sp;
		scroll_res.last          = 1'b1;

		clear_res         = '0;
		clear_res.command = CMD_CLEAR;
		clear_res.last    = 1'b1;

		if (draw) begin
			res0 = draw_res;
		end else if (scroll) begin
			res0 = scroll_res;
		end else begin
			res0 = clear_res;
		end
		res1 = scroll_res;

		res_cnt = step ? (2'(draw) + 2'(scroll) + 2'(clear)) : 2'd0;
	end

endmodule

`default_nettype wire

// ===== rtl/tcec_res_fifo.sv =====
// Result queue that takes up to two beats per cycle and delivers one per pop.
`timescale 1ns / 1ps
`default_nettype none

module tcec_res_fifo (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic [1:0] push_cnt,
	input  wire tcec_pkg::res_t d0,
	input  wire tcec_pkg::res_t d1,
	input  wire logic      pop,
	output logic           head_valid,
	output tcec_pkg::res_t head,
	output logic           room
);
	import tcec_pkg::*;

	res_t             mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	// Entry storage; the second beat lands one slot after the first.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_q] <= d0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_q + PTR_W'(1)] <= d1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push_cnt);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = mem[rd_q];
	// Space for a full two-beat item, judged on the registered count.
	assign room       = (count_q <= CNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

// ===== rtl/tcec_checker.sv =====
// Port-level checks for the text console engine and their bind.
`timescale 1ns / 1ps
`default_nettype none

module tcec_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  command,
	input wire logic [11:0] pos_x,
	input wire logic [11:0] pos_y,
	input wire logic [7:0]  glyph,
	input wire logic [6:0]  scroll_pixels,
	input wire logic        last
);
	import tcec_pkg::*;

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) && $stable(pos_x)
			&& $stable(pos_y) && $stable(glyph) && $stable(scroll_pixels) && $stable(last))
		else $error("output beat changed while stalled");

	// A draw beat carries no scroll amount.
	a_draw_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == CMD_DRAW |-> scroll_pixels == 7'd0)
		else $error("draw beat with nonzero scroll amount");

	// A scroll beat carries no position or glyph and always ends its byte.
	a_scroll_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == CMD_SCROLL |->
			last && pos_x == 12'd0 && pos_y == 12'd0 && glyph == 8'd0)
		else $error("malformed scroll beat");

	// A clear beat is empty and always ends its byte.
	a_clear_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == CMD_CLEAR |->
			last && pos_x == 12'd0 && pos_y == 12'd0 && glyph == 8'd0
			&& scroll_pixels == 7'd0)
		else $error("malformed clear beat");

endmodule

bind text_console_escape_cursor_engine tcec_checker u_tcec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.command       (command),
	.pos_x         (pos_x),
	.pos_y         (pos_y),
	.glyph         (glyph),
	.scroll_pixels (scroll_pixels),
	.last          (last)
);

`default_nettype wire
